>>> rtl/gbl_pkg.sv
// Package for the 3x3 RGB blur: transfer payload structs, control struct,
// register indexes, kernel weights and fixed field widths. No dependencies.
`default_nettype none

package gbl_pkg;

    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 3 * CHAN_W;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int SUM_W      = 12;
    localparam int TAPS       = 9;

    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // window tap i = column (i/3) * 3 + row (i%3); weights 1 2 1 / 2 4 2 / 1 2 1
    localparam logic [2:0] KERNEL_WEIGHT [TAPS] = '{
        3'd1, 3'd2, 3'd1,
        3'd2, 3'd4, 3'd2,
        3'd1, 3'd2, 3'd1
    };

    typedef struct packed {
        logic              opcode;
        logic [CHAN_W-1:0] pixel_red;
        logic [CHAN_W-1:0] pixel_green;
        logic [CHAN_W-1:0] pixel_blue;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              frame_last;
    } out_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // per-transfer decisions from the position counters
    typedef struct packed {
        logic push;    // pixel enters the line buffers and window
        logic emit;    // this transfer yields an output pixel
        logic border;  // that output is a copied border pixel
        logic last;    // that output closes the frame
    } step_t;

endpackage

`default_nettype wire

>>> rtl/gbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gbl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/gbl_ctrl.sv
// Frame geometry registers and input/output position counters for the blur.
// Depends on gbl_pkg.
`default_nettype none

module gbl_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write_en,
    input  wire logic [gbl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gbl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            accept,
    input  wire logic                            opcode,
    output      logic [$clog2(MAX_WIDTH)-1:0]    col,
    output      gbl_pkg::step_t                  step
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int IRW = $clog2(MAX_HEIGHT + 3);
    localparam int DWW = (WW > gbl_pkg::CFG_DATA_W) ? WW : gbl_pkg::CFG_DATA_W;
    localparam int DWH = (HW > gbl_pkg::CFG_DATA_W) ? HW : gbl_pkg::CFG_DATA_W;
    localparam int W_RST = (gbl_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : gbl_pkg::IMAGE_WIDTH_RESET;
    localparam int H_RST = (gbl_pkg::IMAGE_HEIGHT_RESET > MAX_HEIGHT) ?
                           MAX_HEIGHT : gbl_pkg::IMAGE_HEIGHT_RESET;

    logic [WW-1:0]  w_reg, w_next;
    logic [HW-1:0]  h_reg, h_next;
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [IRW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [RW-1:0]  out_row_reg, out_row_next;

    logic [DWW-1:0] cfg_w;
    logic [DWH-1:0] cfg_h;
    logic [WW-1:0]  w_clamp;
    logic [HW-1:0]  h_clamp;
    logic           drain;
    logic           in_col_last;
    logic           out_col_last;
    logic           out_row_last;

    always_comb
    begin
        cfg_w = DWW'(cfg_data);
        cfg_h = DWH'(cfg_data);
        if (cfg_w == '0)
            w_clamp = WW'(1);
        else if (cfg_w > DWW'(MAX_WIDTH))
            w_clamp = WW'(MAX_WIDTH);
        else
            w_clamp = WW'(cfg_w);
        if (cfg_h == '0)
            h_clamp = HW'(1);
        else if (cfg_h > DWH'(MAX_HEIGHT))
            h_clamp = HW'(MAX_HEIGHT);
        else
            h_clamp = HW'(cfg_h);
    end

    always_comb
    begin
        drain        = in_row_reg >= IRW'(h_reg);
        in_col_last  = (WW'(in_col_reg) + WW'(1)) == w_reg;
        out_col_last = (WW'(out_col_reg) + WW'(1)) == w_reg;
        out_row_last = (HW'(out_row_reg) + HW'(1)) == h_reg;

        col         = in_col_reg;
        step.push   = drain || (opcode == gbl_pkg::OP_PIXEL);
        step.emit   = step.push && ((in_row_reg >= IRW'(2)) ||
                      ((in_row_reg == IRW'(1)) && (in_col_reg != '0)));
        step.border = (out_row_reg == '0) || out_row_last ||
                      (out_col_reg == '0) || out_col_last;
        step.last   = out_row_last && out_col_last;
    end

    always_comb
    begin
        w_next       = w_reg;
        h_next       = h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                gbl_pkg::REG_IMAGE_WIDTH:  w_next = w_clamp;
                gbl_pkg::REG_IMAGE_HEIGHT: h_next = h_clamp;
                default:                   w_next = w_reg;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept && step.push)
        begin
            if (in_col_last)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IRW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (step.emit)
            begin
                if (step.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= WW'(W_RST);
            h_reg       <= HW'(H_RST);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

`ifndef SYNTHESIS
    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(in_col_reg) < w_reg)
        else $error("input column outside frame width");

    a_out_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (WW'(out_col_reg) < w_reg) && (HW'(out_row_reg) < h_reg))
        else $error("output position outside frame");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step.emit && step.last) |=>
        (in_col_reg == '0) && (in_row_reg == '0) &&
        (out_col_reg == '0) && (out_row_reg == '0))
        else $error("counters not cleared after last pixel of frame");

    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= (IRW'(h_reg) + IRW'(2)))
        else $error("input row ran past frame drain");
`endif

endmodule

`default_nettype wire

>>> rtl/gbl_lane.sv
// One channel lane of the 3x3 binomial kernel: weighted sum of nine taps >> 4.
// Depends on gbl_pkg.
`default_nettype none

module gbl_lane (
    input  wire logic [gbl_pkg::TAPS-1:0][gbl_pkg::CHAN_W-1:0] taps,
    output      logic [gbl_pkg::CHAN_W-1:0]                    result
);

    logic [gbl_pkg::SUM_W-1:0] sum;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < gbl_pkg::TAPS; i++)
        begin
            sum = sum + gbl_pkg::SUM_W'(taps[i]) *
                        gbl_pkg::SUM_W'(gbl_pkg::KERNEL_WEIGHT[i]);
        end
        result = sum[gbl_pkg::SUM_W-1:4];
    end

endmodule

`default_nettype wire

>>> rtl/gaussian_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB blur: line buffers, window, lanes, merge.
// Depends on gbl_pkg, gbl_ram, gbl_ctrl, gbl_lane.
// A window's last input goes through stage 1, the window and the output register to out_valid.
// Throughput: one input per cycle when not stalled; output pixel n follows input W+n+1.
// Output register stalls hold the whole three-stage pipeline in place.
// Reset: geometry 640x480 (clamped to MAX), counters and window cleared.
`default_nettype none

module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output      logic                            in_stall,
    input  wire gbl_pkg::in_item_t               in_data,
    output      logic                            out_valid,
    input  wire logic                            out_stall,
    output      gbl_pkg::out_item_t              out_data,
    input  wire logic                            cfg_write_en,
    input  wire logic [gbl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gbl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                   adv;
    logic                   accept;
    logic [CW-1:0]          col;
    gbl_pkg::step_t         step;
    gbl_pkg::pixel_t        pix_in;

    logic                   s1_valid_reg, s1_valid_next;
    logic [CW-1:0]          s1_col_reg;
    gbl_pkg::pixel_t        s1_pix_reg;
    gbl_pkg::step_t         s1_step_reg;
    logic                   s1_byp_reg, s1_byp_next;
    gbl_pkg::pixel_t        s1_byp_up_reg;
    gbl_pkg::pixel_t        s1_byp_mid_reg;
    logic [gbl_pkg::PIXEL_W-1:0] up_rdata, mid_rdata;
    gbl_pkg::pixel_t        s1_up, s1_mid;
    logic                   line_we;

    gbl_pkg::pixel_t        win_reg [gbl_pkg::TAPS];
    logic                   s2_valid_reg;
    logic                   s2_border_reg;
    logic                   s2_last_reg;

    logic [2:0][gbl_pkg::TAPS-1:0][gbl_pkg::CHAN_W-1:0] lane_taps;
    logic [2:0][gbl_pkg::CHAN_W-1:0]                    lane_res;

    logic                   out_valid_reg;
    gbl_pkg::out_item_t     out_data_reg, out_data_next;

    assign in_stall  = out_valid_reg && out_stall;
    assign adv       = !in_stall;
    assign accept    = in_valid && adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    gbl_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .opcode       (in_data.opcode),
        .col          (col),
        .step         (step)
    );

    // drain ticks push a black pixel for a flush, else the input pixel
    always_comb
    begin
        if (in_data.opcode == gbl_pkg::OP_PIXEL)
        begin
            pix_in.red   = in_data.pixel_red;
            pix_in.green = in_data.pixel_green;
            pix_in.blue  = in_data.pixel_blue;
        end
        else
        begin
            pix_in = '0;
        end
    end

    gbl_ram #(
        .WIDTH (gbl_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_col_reg),
        .wdata (s1_mid),
        .re    (accept && step.push),
        .raddr (col),
        .rdata (up_rdata)
    );

    gbl_ram #(
        .WIDTH (gbl_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (accept && step.push),
        .raddr (col),
        .rdata (mid_rdata)
    );

    // stage 1: line buffer data back; forward the write of the previous transfer
    always_comb
    begin
        s1_up   = s1_byp_reg ? s1_byp_up_reg  : gbl_pkg::pixel_t'(up_rdata);
        s1_mid  = s1_byp_reg ? s1_byp_mid_reg : gbl_pkg::pixel_t'(mid_rdata);
        line_we = s1_valid_reg && adv;
        s1_valid_next = accept && step.push;
        s1_byp_next   = s1_valid_reg && (s1_col_reg == col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_byp_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s1_valid_next;
            s1_byp_reg   <= s1_byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_col_reg     <= col;
            s1_pix_reg     <= pix_in;
            s1_step_reg    <= step;
            s1_byp_up_reg  <= s1_mid;
            s1_byp_mid_reg <= s1_pix_reg;
        end
    end

    // stage 2: 3x3 window, newest column at taps 6..8
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gbl_pkg::TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
            s2_valid_reg  <= 1'b0;
            s2_border_reg <= 1'b0;
            s2_last_reg   <= 1'b0;
        end
        else if (adv)
        begin
            if (s1_valid_reg)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    win_reg[i] <= win_reg[i + 3];
                end
                win_reg[6] <= s1_up;
                win_reg[7] <= s1_mid;
                win_reg[8] <= s1_pix_reg;
            end
            s2_valid_reg  <= s1_valid_reg && s1_step_reg.emit;
            s2_border_reg <= s1_step_reg.border;
            s2_last_reg   <= s1_step_reg.last;
        end
    end

    always_comb
    begin
        for (int i = 0; i < gbl_pkg::TAPS; i++)
        begin
            lane_taps[0][i] = win_reg[i].red;
            lane_taps[1][i] = win_reg[i].green;
            lane_taps[2][i] = win_reg[i].blue;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        gbl_lane u_lane (
            .taps   (lane_taps[c]),
            .result (lane_res[c])
        );
    end

    // stage 3: merge lanes or copy the center for border pixels
    always_comb
    begin
        if (s2_border_reg)
        begin
            out_data_next.out_red   = win_reg[4].red;
            out_data_next.out_green = win_reg[4].green;
            out_data_next.out_blue  = win_reg[4].blue;
        end
        else
        begin
            out_data_next.out_red   = lane_res[0];
            out_data_next.out_green = lane_res[1];
            out_data_next.out_blue  = lane_res[2];
        end
        out_data_next.frame_last = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_line_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv) |=> !s1_valid_reg || $past(accept))
        else $error("line buffer stage held a transfer twice");

    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s1_valid_reg) && $stable(s2_valid_reg))
        else $error("pipeline moved while output was stalled");

    a_bypass_only_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_byp_reg && $past(adv)) |-> $past(line_we))
        else $error("forwarding without a preceding line buffer write");
`endif

endmodule

`default_nettype wire

>>> tb/gbl_checker.sv
// Checker for the 3x3 RGB blur: follows the input, output and register ports,
// keeps its own line buffers, window and counters, and compares every output.
// Depends on gbl_pkg.
`default_nettype none

module gbl_checker
    import gbl_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire in_item_t              in_data,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire out_item_t             out_data,
    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         pending,
    output int                         failures
);

    localparam int SHOWN_LIMIT = 40;

    logic [PIXEL_W-1:0]    upper_row  [MAX_WIDTH];
    logic [PIXEL_W-1:0]    middle_row [MAX_WIDTH];
    logic [PIXEL_W-1:0]    win        [TAPS];
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    int                    col_pos;
    int                    row_pos;
    int                    out_idx;
    int                    result_no;
    int                    err_count = 0;
    out_item_t             blurred_q [$];

    assign failures = err_count;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [CHAN_W-1:0] blur_channel(input int shift);
        int sum;
        int t;
        sum = 0;
        for (t = 0; t < TAPS; t++)
        begin
            sum += int'(KERNEL_WEIGHT[t]) * int'((win[t] >> shift) & 24'hFF);
        end
        return CHAN_W'(sum >> 4);
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= SHOWN_LIMIT)
        begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        if (idx == REG_IMAGE_WIDTH)
        begin
            width_reg = value;
        end
        else if (idx == REG_IMAGE_HEIGHT)
        begin
            height_reg = value;
        end
        col_pos = 0;
        row_pos = 0;
        out_idx = 0;
    endtask

    task automatic absorb_item(input in_item_t item);
        int                 w;
        int                 h;
        int                 col;
        int                 k;
        int                 orow;
        int                 ocol;
        logic [PIXEL_W-1:0] pix;
        logic [PIXEL_W-1:0] up;
        logic [PIXEL_W-1:0] mid;
        out_item_t          res;
        w = clamp_dim(int'(width_reg), MAX_WIDTH);
        h = clamp_dim(int'(height_reg), MAX_HEIGHT);
        if (row_pos >= h)
        begin
            pix = '0;
        end
        else if (item.opcode == OP_FLUSH)
        begin
            return;
        end
        else
        begin
            pix = {item.pixel_red, item.pixel_green, item.pixel_blue};
        end

        col = (col_pos >= w) ? 0 : col_pos;
        up  = upper_row[col];
        mid = middle_row[col];
        upper_row[col]  = mid;
        middle_row[col] = pix;
        for (k = 0; k < TAPS - 3; k++)
        begin
            win[k] = win[k + 3];
        end
        win[6] = up;
        win[7] = mid;
        win[8] = pix;

        k = row_pos * w + col;
        col_pos = col + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (k < w + 1)
        begin
            return;
        end

        orow = out_idx / w;
        ocol = out_idx % w;
        if (orow == 0 || orow + 1 >= h || ocol == 0 || ocol + 1 >= w)
        begin
            {res.out_red, res.out_green, res.out_blue} = win[4];
        end
        else
        begin
            res.out_red   = blur_channel(16);
            res.out_green = blur_channel(8);
            res.out_blue  = blur_channel(0);
        end
        out_idx++;
        res.frame_last = 1'b0;
        if (out_idx >= w * h)
        begin
            res.frame_last = 1'b1;
            col_pos = 0;
            row_pos = 0;
            out_idx = 0;
        end
        blurred_q.push_back(res);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (blurred_q.size() == 0)
        begin
            report_mismatch($sformatf("output %0d arrived with none expected", result_no));
            result_no++;
            return;
        end
        want = blurred_q.pop_front();
        if (got.out_red !== want.out_red)
        begin
            report_mismatch($sformatf("output %0d out_red got %0h want %0h",
                                      result_no, got.out_red, want.out_red));
        end
        if (got.out_green !== want.out_green)
        begin
            report_mismatch($sformatf("output %0d out_green got %0h want %0h",
                                      result_no, got.out_green, want.out_green));
        end
        if (got.out_blue !== want.out_blue)
        begin
            report_mismatch($sformatf("output %0d out_blue got %0h want %0h",
                                      result_no, got.out_blue, want.out_blue));
        end
        if (got.frame_last !== want.frame_last)
        begin
            report_mismatch($sformatf("output %0d frame_last got %0b want %0b",
                                      result_no, got.frame_last, want.frame_last));
        end
        result_no++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int i = 0; i < TAPS; i++)
            begin
                win[i] = '0;
            end
            width_reg  = CFG_DATA_W'(IMAGE_WIDTH_RESET);
            height_reg = CFG_DATA_W'(IMAGE_HEIGHT_RESET);
            col_pos    = 0;
            row_pos    = 0;
            out_idx    = 0;
            result_no  = 0;
            blurred_q.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result(out_data);
            end
            if (cfg_write_en)
            begin
                apply_write(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                absorb_item(in_data);
            end
            pending <= blurred_q.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Top of the blur testbench: clock, reset, frame stimulus with bursty input and
// patterned output stalls, and the verdict. Depends on gbl_pkg, gbl_checker and the block.
`default_nettype none

module testbench;
    import gbl_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int RANDOM_ITEMS  = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int FILL_UNIFORM  = 0;
    localparam int FILL_CORNERS  = 1;
    localparam int FILL_SATURATE = 2;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    in_item_t              in_data      = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    out_item_t             out_data;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int pending;
    int failures;
    int cycles      = 0;
    int burst_left  = 0;
    int counted     = 0;
    int frame_w     = 1;
    int frame_h     = 1;
    int stall_mode  = 0;
    int stall_left  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gaussian_blur_3x3_rgb #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    gbl_checker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .failures     (failures)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: free-running, light, periodic and heavy stall patterns
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ((cycles % 7) < 3);
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    task automatic send_item(input in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 80 : 12);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
    endtask

    task automatic hold_until_drained();
        in_valid  <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] wv,
                                input logic [CFG_DATA_W-1:0] hv);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_IMAGE_WIDTH;
        cfg_data     <= wv;
        @(posedge clk);
        cfg_index    <= REG_IMAGE_HEIGHT;
        cfg_data     <= hv;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        frame_w = (wv == 0) ? 1 : ((wv > MAX_W) ? MAX_W : int'(wv));
        frame_h = (hv == 0) ? 1 : ((hv > MAX_H) ? MAX_H : int'(hv));
    endtask

    task automatic send_flush();
        in_item_t item;
        item.opcode      = OP_FLUSH;
        item.pixel_red   = 8'($urandom);
        item.pixel_green = 8'($urandom);
        item.pixel_blue  = 8'($urandom);
        send_item(item);
    endtask

    // pixels of one frame, with ignored flushes mixed in and rare full holds
    task automatic send_frame(input int count, input int flush_pct, input int fill);
        in_item_t   item;
        logic [2:0] pick;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < flush_pct)
            begin
                send_flush();
            end
            if ($urandom_range(0, 299) == 0)
            begin
                hold_until_drained();
            end
            item.opcode = OP_PIXEL;
            case (fill)
                FILL_CORNERS:  pick = 3'(i);
                FILL_SATURATE: pick = 3'($urandom);
                default:       pick = '0;
            endcase
            if (fill == FILL_UNIFORM)
            begin
                item.pixel_red   = 8'($urandom);
                item.pixel_green = 8'($urandom);
                item.pixel_blue  = 8'($urandom);
            end
            else
            begin
                item.pixel_red   = {8{pick[0]}};
                item.pixel_green = {8{pick[1]}};
                item.pixel_blue  = {8{pick[2]}};
            end
            send_item(item);
            counted++;
        end
    endtask

    // tail of a frame: any opcode and any data push a pixel (a zero pixel for a flush)
    task automatic send_drain(input int count);
        in_item_t item;
        for (int i = 0; i < count; i++)
        begin
            item.opcode      = 1'($urandom);
            item.pixel_red   = 8'($urandom);
            item.pixel_green = 8'($urandom);
            item.pixel_blue  = 8'($urandom);
            send_item(item);
            counted++;
        end
    endtask

    task automatic send_full_frame(input int flush_pct, input int fill);
        send_frame(frame_w * frame_h, flush_pct, fill);
        send_drain(frame_w + 1);
    endtask

    initial
    begin
        int frames;
        int cut;
        logic [CFG_DATA_W-1:0] wv;
        logic [CFG_DATA_W-1:0] hv;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: single interior pixel, all-border frames, clamped 1x1
        set_geometry(3, 3);
        send_flush();
        send_frame(9, 20, FILL_CORNERS);
        send_drain(4);
        set_geometry(2, 2);
        send_full_frame(0, FILL_CORNERS);
        set_geometry(0, 0);
        send_full_frame(0, FILL_SATURATE);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    wv = CFG_DATA_W'($urandom_range(0, 2));
                    hv = CFG_DATA_W'($urandom_range(0, 12));
                end
                1:
                begin
                    wv = CFG_DATA_W'($urandom_range(1, 12));
                    hv = CFG_DATA_W'($urandom_range(0, 2));
                end
                2:
                begin
                    wv = 3;
                    hv = 3;
                end
                3:
                begin
                    wv = CFG_DATA_W'($urandom_range(20, 40));
                    hv = CFG_DATA_W'($urandom_range(3, 6));
                end
                default:
                begin
                    wv = CFG_DATA_W'($urandom_range(3, 16));
                    hv = CFG_DATA_W'($urandom_range(3, 10));
                end
            endcase
            set_geometry(wv, hv);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                if (frame_w * frame_h > 1 && $urandom_range(0, 9) == 0)
                begin
                    // abandoned frame; the next register write restarts it
                    cut = $urandom_range(1, frame_w * frame_h - 1);
                    send_frame(cut, 5, FILL_UNIFORM);
                    break;
                end
                send_full_frame(5, ($urandom_range(0, 4) == 0) ? FILL_SATURATE
                                                                : FILL_UNIFORM);
            end
        end

        // largest height, reached through an out-of-range value
        set_geometry(11'd1, 11'd2047);
        send_full_frame(1, FILL_UNIFORM);
        set_geometry(11'd5, 11'd4);
        send_full_frame(5, FILL_SATURATE);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
